### hdl/sobel_edge_magnitude_top_defines.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sem_pkg.sv
// Types and constants shared by the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

  // Field widths of the pixel and result transfers.
  localparam int PIX_W  = 8;
  localparam int X_W    = 11;
  localparam int Y_W    = 12;

  // Configuration register widths and limits.
  localparam int CFG_WID_W  = 12;
  localparam int CFG_HGT_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WIDTH_LIMIT  = 2048;
  localparam int HEIGHT_LIMIT = 4096;

  // Internal counter and arithmetic widths.
  localparam int ROW_W  = 13;
  localparam int POS_W  = 23;
  localparam int TOT_W  = 24;
  localparam int IDX_W  = 26;
  localparam int GRAD_W = 11;
  localparam int MAG2_W = 21;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_START,
    S_WAIT
  } sem_state_e;

  // One row store word: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } sem_rows_t;

endpackage

`default_nettype wire

### hdl/sem_if.sv
// Stream interfaces for pixel input and edge result output.
`default_nettype none

interface sem_pix_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface sem_res_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic [X_W-1:0]   out_x;
  logic [Y_W-1:0]   out_y;
  logic             frame_end;

  modport source (output valid, output edge_value, output out_x, output out_y,
                  output frame_end, input ready);
  modport sink (input valid, input edge_value, input out_x, input out_y,
                input frame_end, output ready);
endinterface

`default_nettype wire

### hdl/sem_row_mem.sv
// Row store memory holding the two previous rows, one word per column.
`default_nettype none

module sem_row_mem #(
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [AW-1:0]         waddr_i,
  input  sem_pkg::sem_rows_t   wdata_i,
  input  wire                  re_i,
  input  wire [AW-1:0]         raddr_i,
  output sem_pkg::sem_rows_t   rdata_o
);
  import sem_pkg::*;

  sem_rows_t mem_q [DEPTH];
  sem_rows_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/sem_mag.sv
// Bit-serial integer square root with clamp to 255, one result bit per cycle.
`default_nettype none

module sem_mag (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire [sem_pkg::MAG2_W-1:0] m2_i,
  output logic                      busy_o,
  output logic [sem_pkg::PIX_W-1:0] mag_o
);
  import sem_pkg::*;

  localparam int BIT_W = $clog2(PIX_W);

  logic              busy_q;
  logic [BIT_W-1:0]  k_q;
  logic [MAG2_W-1:0] m2_q;
  logic [PIX_W-1:0]  root_q;
  logic              sat_q;
  logic [PIX_W-1:0]  trial;
  logic [2*PIX_W-1:0] trial_sq;

  // Candidate root with the current bit set, and its square.
  assign trial    = root_q | (PIX_W'(1) << k_q);
  assign trial_sq = trial * trial;

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= BIT_W'(PIX_W - 1);
    end else if (busy_q) begin
      if (k_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q - BIT_W'(1);
      end
    end
  end

  // Root bits are kept when the trial square does not exceed the operand.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m2_q   <= m2_i;
      root_q <= '0;
      sat_q  <= |m2_i[MAG2_W-1:2*PIX_W];
    end else if (busy_q) begin
      if (MAG2_W'(trial_sq) <= m2_q) begin
        root_q <= trial;
      end
    end
  end

  assign busy_o = busy_q;
  assign mag_o  = sat_q ? '1 : root_q;

endmodule

`default_nettype wire

### hdl/sem_div.sv
// Restoring divider that splits a raster position into row and column.
`default_nettype none

module sem_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [sem_pkg::POS_W-1:0]     dividend_i,
  input  wire [sem_pkg::CFG_WID_W-1:0] divisor_i,
  output logic                         busy_o,
  output logic [sem_pkg::Y_W-1:0]      quot_o,
  output logic [sem_pkg::X_W-1:0]      rem_o
);
  import sem_pkg::*;

  localparam int CNT_W = $clog2(POS_W);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [POS_W-1:0]     dq_q;
  logic [X_W-1:0]       rem_q;
  logic [CFG_WID_W-1:0] dvsr_q;
  logic [CFG_WID_W-1:0] shifted;
  logic                 fits;

  // One quotient bit per cycle: shift in the next dividend bit and subtract.
  assign shifted = {rem_q, dq_q[POS_W-1]};
  assign fits    = shifted >= dvsr_q;

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(POS_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q   <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[POS_W-2:0], fits};
      rem_q <= fits ? X_W'(shifted - dvsr_q) : X_W'(shifted);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q[Y_W-1:0];
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### hdl/sobel_edge_magnitude_top.sv
// Streaming 3x3 Sobel edge magnitude over a raster frame; the two previous rows sit in one row store.
// Sequence: an accepted pixel transfer passes the read and update states (S_READ, S_CALC); one
// that causes a result then starts the 8-step square root, and the output register loads once
// it is done and the output is free. The first result after a width write also waits for the
// 23-step divider that re-derives the output column and row. No new pixel is taken before S_IDLE.
// Reset clears counters, window and control registers (width 640, height 480); row store keeps X.
`default_nettype none

`include "sobel_edge_magnitude_top_defines.svh"

module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [sem_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [sem_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sem_pix_if.sink                          pix_i,
  sem_res_if.source                        res_o
);
  import sem_pkg::*;

  localparam int WLIM = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Sign-extend-free widening of a pixel into the gradient width.
  function automatic logic signed [GRAD_W-1:0] zx(input logic [PIX_W-1:0] p);
    zx = signed'({{(GRAD_W - PIX_W){1'b0}}, p});
  endfunction

  sem_state_e state_q, state_d;

  // Configuration and derived frame geometry.
  logic [CFG_WID_W-1:0] width_q;
  logic [CFG_HGT_W-1:0] height_q;
  logic [CFG_WID_W-1:0] eff_w;
  logic [CFG_HGT_W-1:0] eff_h;
  logic [TOT_W-1:0]     total_q;

  // Frame counters and window.
  logic [X_W-1:0]   col_q;
  logic [ROW_W-1:0] row_q;
  logic [POS_W-1:0] opos_q;
  logic [X_W-1:0]   ox_q;
  logic [Y_W-1:0]   oy_q;
  logic             resync_q;
  logic [PIX_W-1:0] win_q [6];

  // Per-item working registers.
  logic [PIX_W-1:0]         pix_q;
  logic                     flush_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic signed [GRAD_W-1:0] gx_d, gy_d;
  logic [MAG2_W-1:0]        m2_q;
  logic [POS_W-1:0]         epos_q;
  logic [X_W-1:0]           ex_q;
  logic [Y_W-1:0]           ey_q;
  logic                     efe_q;
  logic                     div_run_q;
  logic                     fix_q;

  // Output register.
  logic             res_valid_q;
  logic [PIX_W-1:0] res_edge_q;
  logic [X_W-1:0]   res_x_q;
  logic [Y_W-1:0]   res_y_q;
  logic             res_fe_q;

  // Row store and arithmetic units.
  logic      mem_re, mem_we;
  logic [AW-1:0] mem_addr;
  sem_rows_t mem_wdata, mem_rdata;
  logic      mag_busy, div_busy;
  logic [PIX_W-1:0] mag_val;
  logic [Y_W-1:0]   div_q;
  logic [X_W-1:0]   div_r;

  // Combinational decisions of the update cycle.
  logic                     pix_xfer;
  logic                     idx_done, is_pix, pos_lt, pix_emit, emit_c, restart_c;
  logic [TOT_W-1:0]         pos1;
  logic [CFG_WID_W-1:0]     col_nx;
  logic signed [2*GRAD_W-1:0] sq_x, sq_y;
  logic                     out_free, load_out;
  logic [X_W-1:0]           x_adv, fx_adv;
  logic [Y_W-1:0]           y_adv, fy_adv;
  logic [CFG_WID_W-1:0]     x_nx, fx_nx;

  // Effective width and height: zero reads as one, large values clamp.
  always_comb begin
    if (width_q == '0) begin
      eff_w = CFG_WID_W'(1);
    end else if (width_q > CFG_WID_W'(WLIM)) begin
      eff_w = CFG_WID_W'(WLIM);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = CFG_HGT_W'(1);
    end else if (height_q > CFG_HGT_W'(HEIGHT_LIMIT)) begin
      eff_h = CFG_HGT_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
  end

  // Frame size, recomputed every cycle.
  always_ff @(posedge clk_i) begin
    total_q <= TOT_W'(eff_w) * TOT_W'(eff_h);
  end

  assign pix_xfer = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == S_IDLE);

  // Row store: read at acceptance, written back in the update cycle.
  assign mem_addr        = AW'(col_q);
  assign mem_re          = pix_xfer;
  assign mem_we          = (state_q == S_CALC) && is_pix;
  assign mem_wdata.upper  = mem_rdata.middle;
  assign mem_wdata.middle = pix_q;

  sem_row_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  sem_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .m2_i    (m2_q),
    .busy_o  (mag_busy),
    .mag_o   (mag_val)
  );

  sem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((state_q == S_START) && div_run_q),
    .dividend_i (epos_q),
    .divisor_i  (eff_w),
    .busy_o     (div_busy),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Sobel kernels on the window: columns left to right are
  // {win 0..2}, {win 3..5}, {upper, middle, incoming pixel}.
  always_comb begin
    gx_d = (zx(mem_rdata.upper) - zx(win_q[0]))
         + ((zx(mem_rdata.middle) - zx(win_q[1])) <<< 1)
         + (zx(pix_q) - zx(win_q[2]));
    gy_d = (zx(win_q[2]) - zx(win_q[0]))
         + ((zx(win_q[5]) - zx(win_q[3])) <<< 1)
         + (zx(pix_q) - zx(mem_rdata.upper));
  end

  assign sq_x = gx_q * gx_q;
  assign sq_y = gy_q * gy_q;

  // Update-cycle decisions: pixel or flush, result or not, frame restart.
  always_comb begin
    idx_done = idx_q >= IDX_W'(total_q);
    is_pix   = !flush_q && !idx_done;
    pos_lt   = TOT_W'(opos_q) < total_q;
    pos1     = TOT_W'(opos_q) + TOT_W'(1);
    pix_emit = (idx_q >= IDX_W'(eff_w) + IDX_W'(1)) && pos_lt;
    emit_c   = is_pix ? pix_emit : (idx_done && pos_lt);
    if (emit_c) begin
      restart_c = pos1 >= total_q;
    end else begin
      restart_c = idx_done && !is_pix && !pos_lt;
    end
    col_nx = CFG_WID_W'(col_q) + CFG_WID_W'(1);
  end

  // Output column/row advance, from the counters and from the divider.
  always_comb begin
    x_nx = CFG_WID_W'(ox_q) + CFG_WID_W'(1);
    if (x_nx >= eff_w) begin
      x_adv = '0;
      y_adv = oy_q + Y_W'(1);
    end else begin
      x_adv = X_W'(x_nx);
      y_adv = oy_q;
    end
    fx_nx = CFG_WID_W'(div_r) + CFG_WID_W'(1);
    if (fx_nx >= eff_w) begin
      fx_adv = '0;
      fy_adv = div_q + Y_W'(1);
    end else begin
      fx_adv = X_W'(fx_nx);
      fy_adv = div_q;
    end
  end

  assign out_free = !res_valid_q || res_o.ready;
  assign load_out = (state_q == S_WAIT) && !mag_busy && !div_busy && out_free;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (pix_i.valid) state_d = S_READ;
      S_READ:  state_d = S_CALC;
      S_CALC:  state_d = emit_c ? S_START : S_IDLE;
      S_START: state_d = S_WAIT;
      S_WAIT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state: configuration, counters, window and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_WID_W'(640);
      height_q    <= CFG_HGT_W'(480);
      col_q       <= '0;
      row_q       <= '0;
      opos_q      <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      resync_q    <= 1'b0;
      div_run_q   <= 1'b0;
      fix_q       <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      if (state_q == S_CALC) begin
        // Pixel path: shift the window and step the input counters.
        if (is_pix) begin
          win_q[0] <= win_q[3];
          win_q[1] <= win_q[4];
          win_q[2] <= win_q[5];
          win_q[3] <= mem_rdata.upper;
          win_q[4] <= mem_rdata.middle;
          win_q[5] <= pix_q;
          if (col_nx >= eff_w) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= X_W'(col_nx);
          end
        end
        // Result bookkeeping: output position and its column and row.
        if (emit_c) begin
          opos_q    <= POS_W'(pos1);
          div_run_q <= resync_q;
          fix_q     <= resync_q && !restart_c;
          if (!resync_q) begin
            ox_q <= x_adv;
            oy_q <= y_adv;
          end
        end
        // Frame restart: counters and window cleared, row store kept.
        if (restart_c) begin
          col_q    <= '0;
          row_q    <= '0;
          opos_q   <= '0;
          ox_q     <= '0;
          oy_q     <= '0;
          resync_q <= 1'b0;
          for (int i = 0; i < 6; i++) begin
            win_q[i] <= '0;
          end
        end
      end

      // Result transfer into the output register.
      if (load_out) begin
        res_valid_q <= 1'b1;
        if (fix_q) begin
          ox_q     <= fx_adv;
          oy_q     <= fy_adv;
          resync_q <= 1'b0;
        end
      end

      // Configuration writes; a width change forces the divider on the next result.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IMAGE_WIDTH: begin
            width_q  <= cfg_data_i[CFG_WID_W-1:0];
            resync_q <= 1'b1;
          end
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_HGT_W-1:0];
        endcase
      end
    end
  end

  // Working registers of the current item and the output payload.
  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      pix_q   <= pix_i.pixel;
      flush_q <= pix_i.flush;
    end
    if (state_q == S_READ) begin
      idx_q <= IDX_W'(row_q) * IDX_W'(eff_w) + IDX_W'(col_q);
      if ((col_q >= X_W'(2)) && (row_q >= ROW_W'(2))) begin
        gx_q <= gx_d;
        gy_q <= gy_d;
      end else begin
        gx_q <= '0;
        gy_q <= '0;
      end
    end
    if (state_q == S_CALC) begin
      m2_q   <= is_pix ? (MAG2_W'(sq_x) + MAG2_W'(sq_y)) : '0;
      epos_q <= opos_q;
      ex_q   <= ox_q;
      ey_q   <= oy_q;
      efe_q  <= (pos1 == total_q);
    end
    if (load_out) begin
      res_edge_q <= mag_val;
      res_x_q    <= div_run_q ? div_r : ex_q;
      res_y_q    <= div_run_q ? div_q : ey_q;
      res_fe_q   <= efe_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.edge_value = res_edge_q;
  assign res_o.out_x      = res_x_q;
  assign res_o.out_y      = res_y_q;
  assign res_o.frame_end  = res_fe_q;

  // Row store addresses stay inside the memory.
  `SEM_ASSERT_IMP(a_col_in_range, 1'b1, int'(col_q) < MAX_WIDTH, "column beyond row store")
  // An accepted transfer is always followed by the row store read cycle.
  `SEM_ASSERT_NXT(a_accept_reads, pix_xfer, state_q == S_READ, "accept without read cycle")
  // Between items the output column counter stays inside the row unless a resync is due.
  `SEM_ASSERT_IMP(a_x_in_row, (state_q == S_IDLE) && !resync_q,
                  CFG_WID_W'(ox_q) < eff_w, "output column counter out of row")

endmodule

`default_nettype wire

### test/sobel_edge_magnitude_top_tb.sv
// Self-checking testbench for the streaming Sobel edge magnitude block.
module sobel_edge_magnitude_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;

  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int STORE_DEPTH    = 2048;

  // One edge result as it leaves the block.
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [X_W-1:0]   out_x;
    logic [Y_W-1:0]   out_y;
    logic             frame_end;
  } edge_result_t;

  // A result typed into the directed table for one pixel transfer.
  typedef struct packed {
    bit           pinned;
    edge_result_t res;
  } table_pin_t;

  typedef enum {
    ROW_WIDTH,
    ROW_HEIGHT,
    ROW_PIXEL,
    ROW_FLUSH
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    int           value;
    bit           pinned;
    edge_result_t res;
  } stim_row_t;

  localparam edge_result_t NO_PIN = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sem_pix_if pix_if ();
  sem_res_if res_if ();

  sobel_edge_magnitude_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // Shadow copy of the frame registers and of the block's frame state.
  logic [CFG_WID_W-1:0] width_reg  = CFG_WID_W'(640);
  logic [CFG_HGT_W-1:0] height_reg = CFG_HGT_W'(480);
  logic [PIX_W-1:0]     upper_row [STORE_DEPTH];
  logic [PIX_W-1:0]     middle_row [STORE_DEPTH];
  logic [PIX_W-1:0]     win_col [6];
  int                   in_col;
  int                   in_row;
  int                   out_pos;

  edge_result_t pending_edges [$];
  table_pin_t   table_pins [$];
  stim_row_t    directed_rows [$];

  int fail_count     = 0;
  int random_items   = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit quiet_tail     = 1'b0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective frame sizes after the zero and upper-limit rules.
  function automatic int frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int frame_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  function automatic bit inputs_done();
    return in_row * frame_width() + in_col >= frame_width() * frame_height();
  endfunction

  function automatic bit frame_at_start();
    return in_col == 0 && in_row == 0 && out_pos == 0;
  endfunction

  function automatic void restart_frame();
    foreach (win_col[i]) win_col[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_pos = 0;
  endfunction

  // Floor square root of the squared gradient, saturated at 255.
  function automatic logic [PIX_W-1:0] root_floor(input int m2);
    int root;
    int trial;
    root = 0;
    if (m2 >= 65536) return 8'hFF;
    for (int b = 128; b > 0; b = b >> 1) begin
      trial = root | b;
      if (trial * trial <= m2) root = trial;
    end
    return PIX_W'(root);
  endfunction

  function automatic void emit_edge(input logic [PIX_W-1:0] mag, input int w, input int total,
                                    output edge_result_t r);
    int pos;
    pos          = out_pos;
    r.edge_value = mag;
    r.out_x      = X_W'(pos % w);
    r.out_y      = Y_W'(pos / w);
    r.frame_end  = (pos + 1 == total);
    out_pos      = pos + 1;
    if (pos + 1 >= total) restart_frame();
  endfunction

  // Advances the shadow state by one accepted transfer; returns 1 when it yields a result.
  function automatic bit sobel_predict(input logic fl, input logic [PIX_W-1:0] px,
                                       output edge_result_t r);
    int w, total, in_index, c;
    int top, mid, cur, gx, gy;
    logic [PIX_W-1:0] mag;
    bit emitting;
    w        = frame_width();
    total    = w * frame_height();
    in_index = in_row * w + in_col;
    if (!fl && in_index < total) begin
      c   = in_col;
      top = upper_row[c];
      mid = middle_row[c];
      cur = px;
      mag = '0;
      // Interior pixels only: the left column of the window is entries 0..2.
      if (c >= 2 && in_row >= 2) begin
        gx  = (top + 2 * mid + cur) - (win_col[0] + 2 * win_col[1] + win_col[2]);
        gy  = (win_col[2] + 2 * win_col[5] + cur) - (win_col[0] + 2 * win_col[3] + top);
        mag = root_floor(gx * gx + gy * gy);
      end
      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = PIX_W'(top);
      win_col[4] = PIX_W'(mid);
      win_col[5] = px;
      upper_row[c]  = PIX_W'(mid);
      middle_row[c] = px;
      emitting = in_index >= w + 1 && out_pos < total;
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = (in_row + 1) & 'h1FFF;
      end
      if (emitting) emit_edge(mag, w, total, r);
      return emitting;
    end
    // A flush before the frame is complete does nothing.
    if (in_index < total) return 1'b0;
    if (out_pos >= total) begin
      restart_frame();
      return 1'b0;
    end
    emit_edge('0, w, total, r);
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      1:       return PIX_W'($urandom_range(96, 160));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_row(input row_kind_e kind, input int value);
    directed_rows.push_back('{kind, value, 1'b0, NO_PIN});
  endfunction

  function automatic void add_pinned(input row_kind_e kind, input int value, input int ev,
                                     input int x, input int y, input bit fe);
    edge_result_t r;
    r = '{PIX_W'(ev), X_W'(x), Y_W'(y), fe};
    directed_rows.push_back('{kind, value, 1'b1, r});
  endfunction

  // Drives one pixel transfer; called and returns at a falling edge.
  task automatic send_item(input logic fl, input logic [PIX_W-1:0] px, input bit pinned,
                           input edge_result_t pin_res);
    if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    table_pins.push_back('{pinned, pin_res});
    pix_if.valid <= 1'b1;
    pix_if.flush <= fl;
    pix_if.pixel <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits for every expected result and for the block to finish its last transfer.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == CFG_IMAGE_WIDTH) width_reg = CFG_WID_W'(value);
    else height_reg = CFG_HGT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int wv, input int hv);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, wv);
    write_reg(CFG_IMAGE_HEIGHT, hv);
  endtask

  // One whole frame: pixels with a little flush noise, then the tail of flushes.
  task automatic run_frame(input bit tail_resize);
    while (!inputs_done()) begin
      if ($urandom_range(0, 24) == 0) begin
        send_item(1'b1, pick_pixel(), 1'b0, NO_PIN);
      end else begin
        send_item(1'b0, pick_pixel(), 1'b0, NO_PIN);
        random_items++;
      end
    end
    // Resizing once every pixel is in touches no row store entry.
    if (tail_resize) begin
      wait_idle();
      write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, 24));
      write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, frame_height()));
    end
    while (!frame_at_start()) begin
      send_item(($urandom_range(0, 6) != 0), pick_pixel(), 1'b0, NO_PIN);
      random_items++;
    end
  endtask

  // Result sink: ready bursts with random stalls.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end
  end

  // Prediction on each pixel transfer, checking on each result transfer, and the watchdog.
  always @(posedge clk) begin : monitor
    edge_result_t predicted;
    edge_result_t want;
    table_pin_t   pin;
    bit           produced;
    if (rst_n) begin
      if (pix_if.valid && pix_if.ready) begin
        produced = sobel_predict(pix_if.flush, pix_if.pixel, predicted);
        pin      = table_pins.pop_front();
        if (pin.pinned) pending_edges.push_back(pin.res);
        else if (produced) pending_edges.push_back(predicted);
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_edges.size() == 0) begin
          $error("unexpected result: x %0d y %0d edge_value %0d", res_if.out_x,
                 res_if.out_y, res_if.edge_value);
          fail_count++;
        end else begin
          want = pending_edges.pop_front();
          if (res_if.edge_value !== want.edge_value) begin
            $error("edge_value: expected %0d, actual %0d", want.edge_value, res_if.edge_value);
            fail_count++;
          end
          if (res_if.out_x !== want.out_x) begin
            $error("out_x: expected %0d, actual %0d", want.out_x, res_if.out_x);
            fail_count++;
          end
          if (res_if.out_y !== want.out_y) begin
            $error("out_y: expected %0d, actual %0d", want.out_y, res_if.out_y);
            fail_count++;
          end
          if (res_if.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, res_if.frame_end);
            fail_count++;
          end
        end
      end
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int wv;
    int hv;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.flush = 1'b0;
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    restart_frame();

    // Directed table. A one-pixel frame: early flush ignored, late pixel acts as a flush.
    add_row(ROW_WIDTH, 1);
    add_row(ROW_HEIGHT, 1);
    add_row(ROW_FLUSH, 0);
    add_row(ROW_PIXEL, 255);
    add_pinned(ROW_PIXEL, 0, 0, 0, 0, 1'b1);
    // A 3x3 frame with a dark left and bright right column: the center saturates.
    add_row(ROW_WIDTH, 3);
    add_row(ROW_HEIGHT, 3);
    add_row(ROW_PIXEL, 0);
    add_row(ROW_PIXEL, 128);
    add_row(ROW_PIXEL, 255);
    add_row(ROW_PIXEL, 0);
    add_pinned(ROW_PIXEL, 7, 0, 0, 0, 1'b0);
    add_pinned(ROW_PIXEL, 255, 0, 1, 0, 1'b0);
    add_pinned(ROW_PIXEL, 0, 0, 2, 0, 1'b0);
    add_pinned(ROW_PIXEL, 200, 0, 0, 1, 1'b0);
    add_pinned(ROW_PIXEL, 255, 255, 1, 1, 1'b0);
    add_pinned(ROW_FLUSH, 0, 0, 2, 1, 1'b0);
    add_pinned(ROW_FLUSH, 0, 0, 0, 2, 1'b0);
    add_pinned(ROW_FLUSH, 0, 0, 1, 2, 1'b0);
    add_pinned(ROW_FLUSH, 0, 0, 2, 2, 1'b1);
    // A ramp frame, then the height shrinks under the pending tail: the flush only restarts.
    for (int i = 1; i <= 9; i++) add_row(ROW_PIXEL, 10 * i);
    add_row(ROW_HEIGHT, 1);
    add_row(ROW_FLUSH, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct   = 30;
    sink_stall_pct = 30;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WIDTH: begin
          wait_idle();
          write_reg(CFG_IMAGE_WIDTH, directed_rows[i].value);
        end
        ROW_HEIGHT: begin
          wait_idle();
          write_reg(CFG_IMAGE_HEIGHT, directed_rows[i].value);
        end
        ROW_PIXEL: send_item(1'b0, PIX_W'(directed_rows[i].value), directed_rows[i].pinned,
                             directed_rows[i].res);
        default: send_item(1'b1, '0, directed_rows[i].pinned, directed_rows[i].res);
      endcase
    end

    // Largest sizes, written above their limits and as zero.
    src_idle_pct   = 10;
    sink_stall_pct = 10;
    set_frame(4095, 0);
    run_frame(1'b0);
    set_frame(0, 8191);
    run_frame(1'b0);

    // Random frames, mostly small, with occasional wide three-row frames.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet_tail     = random_items >= RANDOM_ITEMS * 85 / 100;
      src_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0: begin
            wv = 0;
            hv = $urandom_range(0, 6);
          end
          1: begin
            wv = $urandom_range(64, 300);
            hv = 3;
          end
          2, 3, 4, 5: begin
            wv = $urandom_range(9, 24);
            hv = $urandom_range(1, 6);
          end
          default: begin
            wv = $urandom_range(1, 8);
            hv = $urandom_range(0, 8);
          end
        endcase
        set_frame(wv, hv);
      end
      run_frame(!quiet_tail && $urandom_range(0, 9) == 0);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
